### design/bdew_pkg.sv
// Package for the bit-driven exponential edge waveform block.
// Holds default widths, register indexes, reset values, step counts and the control structs.
// No dependencies.
`timescale 1ns / 1ps

package bdew_pkg;

  localparam int DEF_TIME_BITS = 16;
  localparam int DEF_VOLT_BITS = 16;

  // Configuration register indexes.
  localparam logic [2:0] REG_PERIOD    = 3'd0;
  localparam logic [2:0] REG_ONE_LEVEL = 3'd1;
  localparam logic [2:0] REG_ZERO_LVL  = 3'd2;
  localparam logic [2:0] REG_ONE_TAU   = 3'd3;
  localparam logic [2:0] REG_ZERO_TAU  = 3'd4;

  // Register reset values, truncated to the configured widths at use.
  localparam int PERIOD_RESET    = 1000;
  localparam int ONE_LEVEL_RESET = 4096;
  localparam int ZERO_LVL_RESET  = 0;
  localparam int TAU_RESET       = 100;

  // Exponential unit step counts.
  localparam int DIV_STEPS = 20;
  localparam int SQ_STEPS  = 12;

  typedef struct packed {
    logic load_in;
    logic check;
    logic exp_init;
    logic sel_end;
    logic div_step;
    logic poly1;
    logic poly2;
    logic poly3;
    logic sq_step;
    logic rnd;
    logic mul;
    logic apply_end;
    logic apply_out;
  } bdew_cmd_t;

  typedef struct packed {
    logic boundary;
  } bdew_sts_t;

endpackage

### design/bdew_if.sv
// Channel interfaces for the waveform block: input, result and configuration.
// Standalone; widths are set by the parameters of each instance.
`timescale 1ns / 1ps

interface bdew_in_if #(parameter int TIME_BITS = 16) ();
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] step_ticks;
  logic                 next_bit;
  modport source(output valid, step_ticks, next_bit, input ready);
  modport sink(input valid, step_ticks, next_bit, output ready);
endinterface

interface bdew_out_if #(parameter int VOLT_BITS = 16) ();
  logic                        valid;
  logic                        ready;
  logic signed [VOLT_BITS-1:0] out_voltage;
  logic                        active_bit;
  logic                        bit_taken;
  modport source(output valid, out_voltage, active_bit, bit_taken, input ready);
  modport sink(input valid, out_voltage, active_bit, bit_taken, output ready);
endinterface

interface bdew_cfg_if #(parameter int DATA_BITS = 16) ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           index;
  logic [DATA_BITS-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### design/bdew_ctrl.sv
// Controller state machine of the waveform block.
// Depends on bdew_pkg for the command and status structs.
`timescale 1ns / 1ps

module bdew_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bdew_pkg::bdew_sts_t sts,
  output bdew_pkg::bdew_cmd_t cmd
);
  import bdew_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_EXPI  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_POLY1 = 4'd4;
  localparam logic [3:0] S_POLY2 = 4'd5;
  localparam logic [3:0] S_POLY3 = 4'd6;
  localparam logic [3:0] S_SQ    = 4'd7;
  localparam logic [3:0] S_RND   = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_APPLY = 4'd10;

  localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);
  localparam logic [4:0] SQ_LAST  = 5'(SQ_STEPS - 1);

  logic [3:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       end_r, end_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       out_free;

  assign out_free  = !ovalid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    end_nxt    = end_r;
    ovalid_nxt = ovalid_r && !out_ready;
    cmd        = '0;
    cmd.sel_end = end_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        end_nxt   = sts.boundary;
        state_nxt = S_EXPI;
      end
      S_EXPI: begin
        cmd.exp_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_POLY1;
        end
      end
      S_POLY1: begin
        cmd.poly1 = 1'b1;
        state_nxt = S_POLY2;
      end
      S_POLY2: begin
        cmd.poly2 = 1'b1;
        state_nxt = S_POLY3;
      end
      S_POLY3: begin
        cmd.poly3 = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        cnt_nxt     = cnt_r + 5'd1;
        if (cnt_r == SQ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (end_r) begin
          cmd.apply_end = 1'b1;
          end_nxt       = 1'b0;
          state_nxt     = S_EXPI;
        end else if (out_free) begin
          cmd.apply_out = 1'b1;
          ovalid_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      end_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      end_r    <= end_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_CHECK)
    else $error("accepted item did not move to the boundary check");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && cnt_r == DIV_LAST |=> state_r == S_POLY1)
    else $error("divider did not finish after its step count");

  a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply_out |=> ovalid_r)
    else $error("result was formed without raising valid");

  a_end_second: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply_end |=> state_r == S_EXPI && !end_r)
    else $error("period end did not start the output exponential");

endmodule

### design/bdew_dp.sv
// Datapath of the waveform block: configuration, state, divider, series, squaring, scaling and saturation.
// Depends on bdew_pkg for register indexes, reset values and control structs.
`timescale 1ns / 1ps

module bdew_dp #(
  parameter int TIME_BITS = bdew_pkg::DEF_TIME_BITS,
  parameter int VOLT_BITS = bdew_pkg::DEF_VOLT_BITS,
  parameter int DATA_BITS = (TIME_BITS > VOLT_BITS) ? TIME_BITS : VOLT_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [DATA_BITS-1:0]        cfg_data,
  input  logic [TIME_BITS-1:0]        step_ticks,
  input  logic                        next_bit,
  input  bdew_pkg::bdew_cmd_t         cmd,
  output bdew_pkg::bdew_sts_t         sts,
  output logic signed [VOLT_BITS-1:0] out_voltage,
  output logic                        active_bit,
  output logic                        bit_taken
);
  import bdew_pkg::*;

  localparam int TW = TIME_BITS + 8;
  localparam int VW = VOLT_BITS;
  localparam int QB = DIV_STEPS;

  logic [TIME_BITS-1:0] period_r, one_tau_r, zero_tau_r;
  logic [VW-1:0]        one_lvl_r, zero_lvl_r;
  logic                 driven_r, nb_r, taken_r;
  logic [VW:0]          offset_r;
  logic [TW-1:0]        time_r;
  logic [TW-1:0]        targ;
  logic [TIME_BITS-1:0] tau_sel, tau_fix, tau_r;
  logic                 zero_r;
  logic [TIME_BITS-1:0] rem_r;
  logic [QB-1:0]        qn_r;
  logic [14:0]          z2_r;
  logic [6:0]           z3_r;
  logic [30:0]          e_r;
  logic [16:0]          e16_r;
  logic [VW+1:0]        sc_r;
  logic signed [VW-1:0] ov_r;
  logic                 ob_r, ot_r;

  logic [TIME_BITS:0]   rem2;
  logic                 ge;
  logic [QB+1:0]        z;
  logic [2*QB+3:0]      zz;
  logic [QB+16:0]       zz3;
  logic [15:0]          d6;
  logic [61:0]          pe;
  logic signed [VW+18:0] prod, prod_rnd;
  logic [VW-1:0]        lvl_cur, lvl_nb;
  logic [VW+2:0]        vsum;
  logic [VW-1:0]        vsat;
  logic [TW:0]          tsum;

  assign sts.boundary = time_r >= TW'(period_r);
  assign tau_sel = driven_r ? one_tau_r : zero_tau_r;
  assign tau_fix = (tau_sel == '0) ? TIME_BITS'(1) : tau_sel;
  assign targ    = cmd.sel_end ? TW'(period_r) : time_r;

  // Restoring divider step: one quotient bit a cycle.
  assign rem2 = {rem_r, qn_r[QB-1]};
  assign ge   = rem2 >= {1'b0, tau_r};

  assign z   = {qn_r, 2'b00};
  assign zz  = (2*QB+4)'(z) * (2*QB+4)'(z);
  assign zz3 = (QB+17)'(z2_r) * (QB+17)'(z);
  assign d6  = (16'(z3_r) * 16'd171) >> 10;
  assign pe  = 62'(e_r) * 62'(e_r);

  assign prod     = $signed(offset_r) * $signed({1'b0, e16_r});
  assign prod_rnd = prod + $signed((VW+19)'(32768));

  assign lvl_cur = driven_r ? one_lvl_r : zero_lvl_r;
  assign lvl_nb  = nb_r ? one_lvl_r : zero_lvl_r;
  assign vsum    = {{3{lvl_cur[VW-1]}}, lvl_cur} + {sc_r[VW+1], sc_r};
  assign vsat    = (vsum[VW+2:VW-1] == '0 || vsum[VW+2:VW-1] == '1) ? vsum[VW-1:0] :
                   (vsum[VW+2] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}});
  assign tsum    = {1'b0, time_r} + (TW+1)'(step_ticks);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= TIME_BITS'(PERIOD_RESET);
      one_lvl_r  <= VW'(ONE_LEVEL_RESET);
      zero_lvl_r <= VW'(ZERO_LVL_RESET);
      one_tau_r  <= TIME_BITS'(TAU_RESET);
      zero_tau_r <= TIME_BITS'(TAU_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD:    period_r   <= cfg_data[TIME_BITS-1:0];
        REG_ONE_LEVEL: one_lvl_r  <= cfg_data[VW-1:0];
        REG_ZERO_LVL:  zero_lvl_r <= cfg_data[VW-1:0];
        REG_ONE_TAU:   one_tau_r  <= cfg_data[TIME_BITS-1:0];
        REG_ZERO_TAU:  zero_tau_r <= cfg_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      driven_r <= 1'b0;
      offset_r <= '0;
      time_r   <= '0;
    end else begin
      if (cmd.load_in) begin
        time_r <= tsum[TW] ? '1 : tsum[TW-1:0];
      end
      if (cmd.apply_end) begin
        driven_r <= nb_r;
        offset_r <= {vsat[VW-1], vsat} - {lvl_nb[VW-1], lvl_nb};
        time_r   <= time_r - TW'(period_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) nb_r <= next_bit;
    if (cmd.check) taken_r <= sts.boundary;
    if (cmd.exp_init) begin
      tau_r  <= tau_fix;
      zero_r <= targ >= TW'({tau_fix, 4'b0000});
      rem_r  <= targ[TIME_BITS+3:4];
      qn_r   <= {targ[3:0], {(QB-4){1'b0}}};
    end
    if (cmd.div_step) begin
      rem_r <= ge ? TIME_BITS'(rem2 - {1'b0, tau_r}) : rem2[TIME_BITS-1:0];
      qn_r  <= {qn_r[QB-2:0], ge};
    end
    if (cmd.poly1) z2_r <= 15'((zz + (2*QB+4)'(32'h2000_0000)) >> 30);
    if (cmd.poly2) z3_r <= 7'((zz3 + (QB+17)'(32'h2000_0000)) >> 30);
    if (cmd.poly3) begin
      e_r <= 31'(32'h4000_0000 - 32'(z) + 32'(z2_r >> 1) - 32'(d6));
    end
    if (cmd.sq_step) e_r <= 31'((pe + 62'h2000_0000) >> 30);
    if (cmd.rnd) e16_r <= zero_r ? 17'd0 : 17'((e_r + 31'h2000) >> 14);
    if (cmd.mul) sc_r <= prod_rnd[VW+17:16];
    if (cmd.apply_out) begin
      ov_r <= $signed(vsat);
      ob_r <= driven_r;
      ot_r <= taken_r;
    end
  end

  assign out_voltage = ov_r;
  assign active_bit  = ob_r;
  assign bit_taken   = ot_r;

endmodule

### design/bit_driven_exponential_edge_waveform.sv
// Top level of the bit-driven exponential edge waveform generator.
// Depends on bdew_pkg, the channel interfaces, bdew_ctrl and bdew_dp.
`timescale 1ns / 1ps

// Each input transfer advances time by step_ticks; when the time within the
// current bit reaches the bit period, next_bit is taken, the voltage at the end
// of the old period becomes the start of a new exponential toward the new
// bit's level, and one period is subtracted. Every input transfer produces one
// result transfer carrying the saturated Q3.12 voltage. An item that crosses a
// bit boundary goes through the exponential unit twice, because each exponential
// goes through one shared unit: a restoring divider, a power series and squaring.
// The block accepts a new item while a finished result still waits for its
// transfer. Configuration writes are always ready and should only be issued
// while no item is in flight.
module bit_driven_exponential_edge_waveform #(
  parameter int TIME_BITS = bdew_pkg::DEF_TIME_BITS,
  parameter int VOLT_BITS = bdew_pkg::DEF_VOLT_BITS
) (
  input logic        clk,
  input logic        rst_n,
  bdew_in_if.sink    in_s,
  bdew_out_if.source out_s,
  bdew_cfg_if.sink   cfg_s
);
  import bdew_pkg::*;

  localparam int DATA_BITS = (TIME_BITS > VOLT_BITS) ? TIME_BITS : VOLT_BITS;

  bdew_cmd_t cmd;
  bdew_sts_t sts;

  // Register writes never stall.
  assign cfg_s.ready = 1'b1;

  bdew_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_s.valid),
    .in_ready  (in_s.ready),
    .out_valid (out_s.valid),
    .out_ready (out_s.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bdew_dp #(
    .TIME_BITS (TIME_BITS),
    .VOLT_BITS (VOLT_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_s.valid),
    .cfg_index   (cfg_s.index),
    .cfg_data    (cfg_s.data),
    .step_ticks  (in_s.step_ticks),
    .next_bit    (in_s.next_bit),
    .cmd         (cmd),
    .sts         (sts),
    .out_voltage (out_s.out_voltage),
    .active_bit  (out_s.active_bit),
    .bit_taken   (out_s.bit_taken)
  );

endmodule

### sim/bit_driven_exponential_edge_waveform_tb.sv
// Self-checking testbench for the bit-driven exponential edge waveform block.
// Depends on bdew_pkg, the channel interfaces in bdew_if and the top level.
`timescale 1ns / 1ps

class wave_scoreboard;
  // Register copy.
  logic [15:0] period;
  logic signed [15:0] lvl_one, lvl_zero;
  logic [15:0] tau_one, tau_zero;
  // Predicted block state.
  logic driven;
  longint offset;
  longint t_acc;
  // Pending voltages, bits and taken flags.
  logic [15:0] exp_volt[$];
  logic exp_bit[$];
  logic exp_taken[$];
  int errors;

  function new();
    period = 16'd1000; lvl_one = 16'sd4096; lvl_zero = 16'sd0;
    tau_one = 16'd100; tau_zero = 16'd100;
    driven = 1'b0; offset = 0; t_acc = 0; errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      bdew_pkg::REG_PERIOD:    period = val;
      bdew_pkg::REG_ONE_LEVEL: lvl_one = val;
      bdew_pkg::REG_ZERO_LVL:  lvl_zero = val;
      bdew_pkg::REG_ONE_TAU:   tau_one = val;
      bdew_pkg::REG_ZERO_TAU:  tau_zero = val;
      default: ;
    endcase
  endfunction

  // exp(-t/tau) in Q1.16 through a short series and twelve squarings.
  function longint decay_q16(longint t, longint tau);
    longint r, z, z2, z3, e;
    if (tau == 0) tau = 1;
    if (t >= 16 * tau) return 0;
    r = (t << 16) / tau;
    z = r << 2;
    z2 = (z * z + (64'sd1 << 29)) >>> 30;
    z3 = (z2 * z + (64'sd1 << 29)) >>> 30;
    e = (64'sd1 << 30) - z + z2 / 2 - z3 / 6;
    for (int k = 0; k < 12; k++) e = (e * e + (64'sd1 << 29)) >>> 30;
    return (e + (64'sd1 << 13)) >>> 14;
  endfunction

  function longint scaled(longint off, longint e);
    longint q;
    q = off * e + 32768;
    if (q >= 0) return q >>> 16;
    return -((-q + 65535) >>> 16);
  endfunction

  function longint clip16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function longint level(logic b);
    return b ? longint'(lvl_one) : longint'(lvl_zero);
  endfunction

  function longint tau(logic b);
    return b ? longint'(tau_one) : longint'(tau_zero);
  endfunction

  function void note_input(logic [15:0] step, logic nb);
    longint vend, v;
    logic taken;
    taken = 1'b0;
    t_acc += step;
    if (t_acc > 24'hFFFFFF) t_acc = 24'hFFFFFF;
    if (t_acc >= period) begin
      vend = clip16(level(driven) + scaled(offset, decay_q16(period, tau(driven))));
      driven = nb;
      offset = vend - level(driven);
      t_acc -= period;
      taken = 1'b1;
    end
    v = clip16(level(driven) + scaled(offset, decay_q16(t_acc, tau(driven))));
    exp_volt.push_back(v[15:0]);
    exp_bit.push_back(driven);
    exp_taken.push_back(taken);
  endfunction

  function void check_result(logic [15:0] volt, logic ab, logic tk);
    if (exp_volt.size() == 0) begin
      $error("result transfer with nothing expected");
      errors++;
      return;
    end
    if (volt !== exp_volt[0]) begin
      $error("out_voltage expected %0h actual %0h", exp_volt[0], volt);
      errors++;
    end
    if (ab !== exp_bit[0]) begin
      $error("active_bit expected %0b actual %0b", exp_bit[0], ab);
      errors++;
    end
    if (tk !== exp_taken[0]) begin
      $error("bit_taken expected %0b actual %0b", exp_taken[0], tk);
      errors++;
    end
    void'(exp_volt.pop_front());
    void'(exp_bit.pop_front());
    void'(exp_taken.pop_front());
  endfunction
endclass

module bit_driven_exponential_edge_waveform_tb;
  import bdew_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit calm = 1'b0;  // the closing part of the run has no idling

  bdew_in_if #(.TIME_BITS(16)) in_ch();
  bdew_out_if #(.VOLT_BITS(16)) out_ch();
  bdew_cfg_if #(.DATA_BITS(16)) cfg_ch();

  wave_scoreboard sb = new();

  bit_driven_exponential_edge_waveform dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_ch.sink), .out_s(out_ch.source), .cfg_s(cfg_ch.sink)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.step_ticks = '0; in_ch.next_bit = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_PERIOD; cfg_ch.data = '0;
  end

  // Result side: ready is held low in bursts; every transfer is checked.
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.out_voltage, out_ch.active_bit, out_ch.bit_taken);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 8) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // One input transfer, with an occasional random gap in front of it.
  // Valid stays high between back-to-back transfers; drain() drops it.
  task automatic send_step(logic [15:0] step, logic nb);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.step_ticks <= step;
    in_ch.next_bit <= nb;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(step, nb);
  endtask

  // Valid stays high between writes; set_all() drops it after the last one.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
  endtask

  // Waits out every pending result, then a margin for the block to go idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.exp_volt.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_all(logic [15:0] p, logic [15:0] l1, logic [15:0] l0,
                         logic [15:0] t1, logic [15:0] t0);
    write_reg(REG_PERIOD, p);
    write_reg(REG_ONE_LEVEL, l1);
    write_reg(REG_ZERO_LVL, l0);
    write_reg(REG_ONE_TAU, t1);
    write_reg(REG_ZERO_TAU, t0);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random step: mostly a fraction of the period so that curves are sampled
  // mid-flight, sometimes a full range value.
  function automatic logic [15:0] rand_step(logic [15:0] p);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 16'($urandom_range(0, (p == 0) ? 4 : p / 2 + 1));
    if (sel < 9) return 16'($urandom_range(0, 65535));
    return 16'hFFFF;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_step(rand_step(sb.period), 1'($urandom));
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset values: no boundary, exact boundary, long steps.
    send_step(16'd0, 1'b1);
    send_step(16'd500, 1'b1);
    send_step(16'd500, 1'b1);
    send_step(16'd50, 1'b0);
    send_step(16'hFFFF, 1'b0);
    send_step(16'd999, 1'b1);
    drain();
    // Zero period and zero time constants (treated as one tick).
    set_all(16'd0, 16'h7FFF, 16'h8000, 16'd0, 16'd0);
    send_step(16'd0, 1'b1);
    send_step(16'd1, 1'b0);
    send_step(16'd0, 1'b1);
    send_step(16'd3, 1'b0);
    drain();
    // Extreme levels and longest constants, to saturate the end voltage.
    set_all(16'd40000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
    send_step(16'd40000, 1'b1);
    send_step(16'd40000, 1'b0);
    send_step(16'd1, 1'b1);
    send_step(16'hFFFF, 1'b1);
    // Long steps that cross a bit boundary with every item while the accumulated time grows.
    for (int i = 0; i < 8; i++) send_step(16'hFFFF, 1'($urandom));
    drain();

    // Random phases, each under a new register setting.
    for (int ph = 0; ph < 8; ph++) begin
      set_all(16'($urandom_range(1, (ph % 2) ? 65535 : 600)), 16'($urandom),
              16'($urandom), 16'($urandom_range(0, (ph % 3) ? 400 : 65535)),
              16'($urandom_range(0, 400)));
      random_phase(75);
      drain();
    end
    // Closing part without idling on either side.
    calm = 1'b1;
    set_all(16'd200, 16'h1000, 16'hF000, 16'd40, 16'd60);
    random_phase(50);

    drain();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
